@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by spq_cell, spq_ctrl, sorted_priority_queue_core and the testbench.
package spq_pkg;

	localparam int CAPACITY_DEF  = 16;
	localparam int KEY_WIDTH_DEF = 32;
	localparam int HND_W         = 4;
	localparam int OP_W          = 2;
	localparam int ST_W          = 2;
	localparam int CNT_W         = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELMAX = 2'd1,
		OP_CHANGE = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_UNKNOWN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REINS
	} state_t;

	// source of the result key
	typedef enum logic [1:0] {
		KS_ZERO,
		KS_NEW,
		KS_HEAD,
		KS_NEXT
	} ksel_t;

	// broadcast to every cell
	typedef struct packed {
		logic             ins;
		logic             rm_hnd;
		logic             rm_head;
		logic [HND_W-1:0] hnd;
	} cmd_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic             ge;
		logic             rm;
		logic             valid;
		logic [HND_W-1:0] hnd;
	} link_t;

	// result request from the controller
	typedef struct packed {
		logic             load;
		status_t          status;
		logic [HND_W-1:0] hnd;
		ksel_t            ksel;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

@@ rtl/spq_cell.sv @@
// One slot of the sorted list: key, handle and valid bit.
// Shifts toward the tail on insert and toward the head on removal. Uses spq_pkg.
module spq_cell #(
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_pkg::cmd_t        cmd,
	input  logic [KEY_WIDTH-1:0] cmd_key,
	input  spq_pkg::link_t       prev,
	input  logic [KEY_WIDTH-1:0] prev_key,
	input  spq_pkg::link_t       next,
	input  logic [KEY_WIDTH-1:0] next_key,
	output spq_pkg::link_t       link,
	output logic [KEY_WIDTH-1:0] key,
	output logic                 match
);
	import spq_pkg::*;

	logic                 valid_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [HND_W-1:0]     hnd_q;
	logic                 ge;
	logic                 rm;

	assign match = valid_q && (hnd_q == cmd.hnd);
	assign ge    = valid_q && (key_q >= cmd_key);
	assign rm    = (cmd.rm_hnd && match) || prev.rm;

	assign link.ge    = ge;
	assign link.rm    = rm;
	assign link.valid = valid_q;
	assign link.hnd   = hnd_q;
	assign key        = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins && !ge) begin
			valid_q <= prev.valid;
		end else if (rm) begin
			valid_q <= next.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins && !ge) begin
			if (prev.ge) begin
				key_q <= cmd_key;
				hnd_q <= cmd.hnd;
			end else begin
				key_q <= prev_key;
				hnd_q <= prev.hnd;
			end
		end else if (rm) begin
			key_q <= next_key;
			hnd_q <= next.hnd;
		end
	end

	ap_ins_keeps_larger: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins && ge) |=> (valid_q && $stable(key_q) && $stable(hnd_q)))
		else $error("cell lost a larger key on insert");

endmodule

@@ rtl/spq_ctrl.sv @@
// Sequencer for the queue: operation decode, error checks, handle table, count.
// Drives the cell command and the result request. Uses spq_pkg.
module spq_ctrl #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  spq_pkg::op_t              in_op,
	input  logic [spq_pkg::HND_W-1:0] in_hnd,
	output logic                      in_ready,
	input  logic                      out_free,
	input  logic [spq_pkg::HND_W-1:0] head_hnd,
	output spq_pkg::cmd_t             cmd,
	output spq_pkg::res_t             res
);
	import spq_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t           state_q, state_d;
	op_t              op_q;
	logic [HND_W-1:0] hnd_q;
	logic [CNT_W-1:0] occ_q;
	logic [CAPACITY-1:0] in_use_q;

	logic             free_ok;
	logic [IDX_W-1:0] free_idx;
	logic             hnd_known;
	status_t          chk;

	logic             set_en, clr_en, occ_inc, occ_dec;
	logic [IDX_W-1:0] set_idx, clr_idx;

	// checks on the held operation
	always_comb begin
		free_ok  = 1'b0;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_ok  = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
		hnd_known = ({1'b0, hnd_q} < (HND_W + 1)'(CAPACITY)) && in_use_q[hnd_q[IDX_W-1:0]];
		unique case (op_q)
			OP_INSERT: chk = (occ_q >= CNT_W'(CAPACITY) || !free_ok) ? ST_FULL : ST_OK;
			OP_DELMAX: chk = (occ_q == '0) ? ST_EMPTY : ST_OK;
			OP_CHANGE,
			OP_DELETE: chk = hnd_known ? ST_OK : ST_UNKNOWN;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_CHANGE && chk == ST_OK) state_d = S_REINS;
				else if (out_free) state_d = S_IDLE;
			end
			S_REINS: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.hnd     = hnd_q;
		res         = '0;
		res.status  = ST_OK;
		res.ksel    = KS_ZERO;
		set_en      = 1'b0;
		clr_en      = 1'b0;
		set_idx     = free_idx;
		clr_idx     = hnd_q[IDX_W-1:0];
		occ_inc     = 1'b0;
		occ_dec     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
			end
			S_EXEC: begin
				if (op_q == OP_CHANGE && chk == ST_OK) begin
					cmd.rm_hnd = 1'b1;
					occ_dec    = 1'b1;
				end else if (out_free) begin
					res.load   = 1'b1;
					res.status = chk;
					if (chk == ST_OK) begin
						unique case (op_q)
							OP_INSERT: begin
								cmd.ins  = 1'b1;
								cmd.hnd  = HND_W'(free_idx);
								set_en   = 1'b1;
								occ_inc  = 1'b1;
								res.hnd  = HND_W'(free_idx);
								res.ksel = KS_NEW;
							end
							OP_DELMAX: begin
								cmd.rm_head = 1'b1;
								clr_en      = 1'b1;
								clr_idx     = head_hnd[IDX_W-1:0];
								occ_dec     = 1'b1;
								res.hnd     = head_hnd;
								res.ksel    = KS_HEAD;
							end
							OP_DELETE: begin
								cmd.rm_hnd = 1'b1;
								clr_en     = 1'b1;
								occ_dec    = 1'b1;
								res.hnd    = hnd_q;
								res.ksel   = KS_NEXT;
							end
							default: ;
						endcase
					end
				end
			end
			S_REINS: begin
				if (out_free) begin
					cmd.ins  = 1'b1;
					occ_inc  = 1'b1;
					res.load = 1'b1;
					res.hnd  = hnd_q;
					res.ksel = KS_NEW;
				end
			end
			default: ;
		endcase
		res.count = occ_q + CNT_W'(occ_inc) - CNT_W'(occ_dec);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			occ_q    <= '0;
			in_use_q <= '0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_q + CNT_W'(occ_inc) - CNT_W'(occ_dec);
			if (set_en) in_use_q[set_idx] <= 1'b1;
			if (clr_en) in_use_q[clr_idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= in_op;
			hnd_q <= in_hnd;
		end
	end

	ap_handles_track_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_REINS) |-> ($countones(in_use_q) == 32'(occ_q)))
		else $error("handle table out of step with occupancy");

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	ap_reinsert_follows_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REINS) |-> (op_q == OP_CHANGE && occ_q < CNT_W'(CAPACITY)))
		else $error("reinsert without a preceding change removal");

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: stream ports, cell chain, result register.
// Depends on spq_pkg, spq_cell and spq_ctrl.
//
// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  operation, key, handle
// m_axis    out  m_tvalid/m_tready  key_out, handle_out, status, is_empty, entry_count
//
// Change is a removal shift, then an insert shift through the cell chain; insert,
// delete-max, delete and every error finish in the execute step.
// A new transaction is taken once the previous one has gone to the result register.
// A stalled result holds the sequencer in its last step; the list is not touched.
// arst_n clears the list, the handle table and the result valid flag at once.
module sorted_priority_queue_core #(
	parameter int CAPACITY  = spq_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
	localparam int IN_W  = ((KEY_WIDTH + spq_pkg::OP_W + spq_pkg::HND_W + 7) / 8) * 8,
	localparam int OUT_W = ((KEY_WIDTH + spq_pkg::HND_W + spq_pkg::ST_W + 1
		+ spq_pkg::CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // operation, key, handle
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // key_out, handle_out, status, is_empty, entry_count
);
	import spq_pkg::*;

	localparam int KEY_LO = OP_W;
	localparam int HND_LO = OP_W + KEY_WIDTH;

	cmd_t                 cmd;
	res_t                 res;
	logic [KEY_WIDTH-1:0] key_q;
	logic                 out_free;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;
	logic [KEY_WIDTH-1:0] res_key;
	logic [KEY_WIDTH-1:0] after_key;

	link_t                cell_link [CAPACITY];
	logic [KEY_WIDTH-1:0] cell_key  [CAPACITY];
	link_t                prev_link [CAPACITY];
	logic [KEY_WIDTH-1:0] prev_key  [CAPACITY];
	link_t                next_link [CAPACITY];
	logic [KEY_WIDTH-1:0] next_key  [CAPACITY];
	logic [CAPACITY-1:0]  cell_match;
	logic [CAPACITY-1:0]  cell_valid;

	assign out_free = !m_tvalid_q || m_tready;

	spq_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (op_t'(s_tdata[OP_W-1:0])),
		.in_hnd   (s_tdata[HND_LO +: HND_W]),
		.in_ready (s_tready),
		.out_free (out_free),
		.head_hnd (cell_link[0].hnd),
		.cmd      (cmd),
		.res      (res)
	);

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) key_q <= s_tdata[KEY_LO +: KEY_WIDTH];
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_link[i] = '{ge: 1'b1, rm: cmd.rm_head, valid: 1'b1, hnd: '0};
			assign prev_key[i]  = '0;
		end else begin : g_mid
			assign prev_link[i] = cell_link[i-1];
			assign prev_key[i]  = cell_key[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign next_link[i] = '0;
			assign next_key[i]  = '0;
		end else begin : g_body
			assign next_link[i] = cell_link[i+1];
			assign next_key[i]  = cell_key[i+1];
		end

		spq_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.cmd_key  (key_q),
			.prev     (prev_link[i]),
			.prev_key (prev_key[i]),
			.next     (next_link[i]),
			.next_key (next_key[i]),
			.link     (cell_link[i]),
			.key      (cell_key[i]),
			.match    (cell_match[i])
		);

		assign cell_valid[i] = cell_link[i].valid;
	end

	// delete reports the key that slides into the freed slot, else the head key
	always_comb begin
		after_key = cell_key[0];
		for (int i = 0; i < CAPACITY - 1; i++) begin
			if (cell_match[i] && cell_valid[i+1]) after_key = cell_key[i+1];
		end
	end

	always_comb begin
		unique case (res.ksel)
			KS_ZERO: res_key = '0;
			KS_NEW:  res_key = key_q;
			KS_HEAD: res_key = cell_key[0];
			KS_NEXT: res_key = after_key;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			m_tdata_q <= OUT_W'({res.count, (res.count == '0), res.status, res.hnd, res_key});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ap_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_valid & (cell_valid + CAPACITY'(1))) == '0)
		else $error("valid slots not packed at the head");

	ap_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |=> ($countones(cell_valid) == 32'(m_tdata_q[KEY_WIDTH + HND_W + ST_W + 1 +: CNT_W])))
		else $error("reported count differs from occupied cells");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sorted_priority_queue_core: directed and random queue traffic.
// Uses spq_pkg; an in-bench queue model predicts every result on the master stream.
module testbench;
	import spq_pkg::*;

	localparam int CAP            = CAPACITY_DEF;
	localparam int KEY_W          = KEY_WIDTH_DEF;
	localparam int IN_W           = ((KEY_W + OP_W + HND_W + 7) / 8) * 8;
	localparam int OUT_W          = ((KEY_W + HND_W + ST_W + 1 + CNT_W + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_OFF       = 300;
	localparam int DRAIN_CYCLES   = 12;
	localparam int CHUNKS         = 15;
	localparam int CHUNK_ITEMS    = 100;

	typedef struct {
		logic [KEY_W-1:0] key;
		logic [HND_W-1:0] hnd;
		status_t          status;
		logic             empty;
		logic [CNT_W-1:0] count;
	} result_t;

	class queue_scoreboard;
		logic [KEY_W-1:0] keys [CAP];
		logic [HND_W-1:0] hnds [CAP];
		logic [CAP-1:0]   in_use;
		int               count;
		result_t          awaited_results[$];
		int               errors;

		function new();
			for (int i = 0; i < CAP; i++) begin
				keys[i] = '0;
				hnds[i] = '0;
			end
			in_use = '0;
			count  = 0;
			errors = 0;
		endfunction

		function void remove_at(int pos);
			for (int i = pos; i + 1 < count; i++) begin
				keys[i] = keys[i+1];
				hnds[i] = hnds[i+1];
			end
			count--;
		endfunction

		// lands after every equal or larger key
		function void place(logic [KEY_W-1:0] key, logic [HND_W-1:0] h);
			int pos;
			pos = 0;
			while (pos < count && keys[pos] >= key)
				pos++;
			for (int i = count; i > pos; i--) begin
				keys[i] = keys[i-1];
				hnds[i] = hnds[i-1];
			end
			keys[pos] = key;
			hnds[pos] = h;
			count++;
		endfunction

		function int locate(logic [HND_W-1:0] h);
			if (!in_use[h])
				return -1;
			for (int i = 0; i < count; i++)
				if (hnds[i] == h)
					return i;
			return -1;
		endfunction

		function result_t apply_operation(op_t op, logic [KEY_W-1:0] key, logic [HND_W-1:0] h);
			result_t r;
			int      idx;
			int      pos;
			r.key    = '0;
			r.hnd    = '0;
			r.status = ST_OK;
			case (op)
				OP_INSERT: begin
					idx = 0;
					while (idx < CAP && in_use[idx])
						idx++;
					if (count >= CAP || idx >= CAP) begin
						r.status = ST_FULL;
					end else begin
						in_use[idx] = 1'b1;
						place(key, HND_W'(idx));
						r.key = key;
						r.hnd = HND_W'(idx);
					end
				end
				OP_DELMAX: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.key = keys[0];
						r.hnd = hnds[0];
						in_use[hnds[0]] = 1'b0;
						remove_at(0);
					end
				end
				default: begin
					pos = locate(h);
					if (pos < 0) begin
						r.status = ST_UNKNOWN;
					end else begin
						remove_at(pos);
						r.hnd = h;
						if (op == OP_CHANGE) begin
							place(key, h);
							r.key = key;
						end else begin
							// key of the entry that moved into the gap, else the head slot
							r.key = keys[pos < count ? pos : 0];
							in_use[h] = 1'b0;
						end
					end
				end
			endcase
			r.empty = (count == 0);
			r.count = CNT_W'(count);
			return r;
		endfunction

		function void note_accepted(op_t op, logic [KEY_W-1:0] key, logic [HND_W-1:0] h);
			awaited_results.push_back(apply_operation(op, key, h));
		endfunction

		task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
			$display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
			errors++;
		endtask

		task check_result(logic [OUT_W-1:0] data);
			result_t want;
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected transaction", data[KEY_W-1:0], '0);
			end else begin
				want = awaited_results.pop_front();
				if (data[KEY_W-1:0] !== want.key)
					report_mismatch("key_out", data[KEY_W-1:0], want.key);
				if (data[KEY_W +: HND_W] !== want.hnd)
					report_mismatch("handle_out", KEY_W'(data[KEY_W +: HND_W]),
						KEY_W'(want.hnd));
				if (data[KEY_W+HND_W +: ST_W] !== want.status)
					report_mismatch("status", KEY_W'(data[KEY_W+HND_W +: ST_W]),
						KEY_W'(want.status));
				if (data[KEY_W+HND_W+ST_W] !== want.empty)
					report_mismatch("is_empty", KEY_W'(data[KEY_W+HND_W+ST_W]),
						KEY_W'(want.empty));
				if (data[KEY_W+HND_W+ST_W+1 +: CNT_W] !== want.count)
					report_mismatch("entry_count", KEY_W'(data[KEY_W+HND_W+ST_W+1 +: CNT_W]),
						KEY_W'(want.count));
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;   // operation, key, handle
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;   // key_out, handle_out, status, is_empty, entry_count

	queue_scoreboard sb;
	int              tx_idle_pct;
	int              rx_stall_pct;
	int              hold_off_left;
	int              quiet_cycles;

	sorted_priority_queue_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic send_item(op_t op, logic [KEY_W-1:0] key, logic [HND_W-1:0] h);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-KEY_W-OP_W-HND_W){1'b0}}, h, key, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_accepted(op, key, h);
	endtask

	// mix 0 fills, 1 drains, 2 balanced
	function automatic op_t pick_op(int mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			0:       return r < 55 ? OP_INSERT : r < 70 ? OP_DELMAX : r < 85 ? OP_CHANGE : OP_DELETE;
			1:       return r < 20 ? OP_INSERT : r < 55 ? OP_DELMAX : r < 70 ? OP_CHANGE : OP_DELETE;
			default: return r < 35 ? OP_INSERT : r < 55 ? OP_DELMAX : r < 80 ? OP_CHANGE : OP_DELETE;
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return KEY_W'($urandom_range(7));
		else if (r < 30)
			return '0;
		else if (r < 35)
			return '1;
		return KEY_W'($urandom());
	endfunction

	// mostly live handles, the rest anything
	function automatic logic [HND_W-1:0] pick_handle();
		logic [HND_W-1:0] h;
		h = HND_W'($urandom_range(CAP-1));
		if (sb.in_use != '0 && $urandom_range(99) < 85)
			while (!sb.in_use[h])
				h = HND_W'($urandom_range(CAP-1));
		return h;
	endfunction

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				m_tready <= 1'b0;
				hold_off_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		int   mix;
		op_t  op;
		sb            = new();
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_off_left = 0;
		quiet_cycles  = 0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// errors on an empty queue
		send_item(OP_DELMAX, '0, '0);
		send_item(OP_DELETE, '1, 4'd5);
		send_item(OP_CHANGE, '1, 4'd15);
		// extremes, equal keys, rekey onto the head key, delete of last and only entry
		send_item(OP_INSERT, '1, '0);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_INSERT, '0, '1);
		send_item(OP_CHANGE, '1, 4'd1);
		send_item(OP_DELETE, '0, 4'd2);
		send_item(OP_DELMAX, '1, '1);
		send_item(OP_DELETE, '0, 4'd1);
		// fill up, then one insert too many
		for (int i = 0; i <= CAP; i++)
			send_item(OP_INSERT, KEY_W'($urandom_range(3)), HND_W'($urandom()));

		for (int c = 0; c < CHUNKS; c++) begin
			case (c % 4)
				0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1:       begin tx_idle_pct = 85; rx_stall_pct = 0;  end
				2:       begin tx_idle_pct = 0;  rx_stall_pct = 85; end
				default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
			endcase
			if (c == 4)
				hold_off_left = HOLD_OFF;
			mix = (c + c / 4) % 3;
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				op = pick_op(mix);
				send_item(op, pick_key(), pick_handle());
			end
		end

		s_tvalid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
